// ===== sv/mam_pkg.sv =====
// Shared types and codes for the array address map.
package mam_pkg;

	localparam logic [1:0] MODE_DEFINE = 2'd0;
	localparam logic [1:0] MODE_BOUND  = 2'd1;
	localparam logic [1:0] MODE_INDEX  = 2'd2;

	typedef struct packed {
		logic        [1:0]  mode;
		logic        [3:0]  array_id;
		logic        [3:0]  dim_slot;
		logic signed [31:0] base_addr;
		logic        [15:0] elem_bytes;
		logic        [3:0]  dim_count;
		logic signed [15:0] lower_bound;
		logic signed [15:0] upper_bound;
		logic signed [15:0] index_value;
		logic               last_index;
	} item_t;

	typedef struct packed {
		logic signed [31:0] phys_addr;
		logic               count_error;
	} result_t;

	typedef struct packed {
		logic [31:0] base;
		logic [15:0] esize;
		logic [3:0]  dims;
	} desc_t;

	typedef struct packed {
		logic [15:0] lower;
		logic [15:0] upper;
	} bound_t;

endpackage

// ===== sv/mam_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module mam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/mam_seq.sv =====
// Request sequencer: table access, running offset update and address scaling.
module mam_seq import mam_pkg::*; #(
	parameter int MAX_ARRAYS = 16,
	parameter int MAX_DIMS   = 10,
	parameter int AW         = 4,
	parameter int BW         = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  item_t         item,
	output logic          result_valid,
	input  logic          result_stall,
	output result_t       result,
	output logic          desc_we,
	output logic [AW-1:0] desc_waddr,
	output desc_t         desc_wdata,
	output logic          desc_re,
	output logic [AW-1:0] desc_raddr,
	input  desc_t         desc_rdata,
	output logic          bnd_we,
	output logic [BW-1:0] bnd_waddr,
	output bound_t        bnd_wdata,
	output logic          bnd_re,
	output logic [BW-1:0] bnd_raddr,
	input  bound_t        bnd_rdata
);

	localparam logic [8:0] ID_LIM   = 9'(MAX_ARRAYS);
	localparam logic [4:0] DIMS_LIM = 5'(MAX_DIMS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_SCALE
	} state_t;

	state_t             state_q;
	logic [31:0]        offset_q;
	logic [3:0]         pos_q;
	logic               last_s1;
	logic               id_ok_s1;
	logic signed [15:0] idx_s1;
	logic [31:0]        extent_s2;
	logic [31:0]        diff_s2;
	logic [31:0]        base_s2;
	logic [15:0]        esize_s2;
	logic               err_s2;
	logic               result_valid_q;
	result_t            result_q;

	logic        accept;
	logic        id_ok;
	logic        slot_ok;
	logic        pos_ok;
	logic [12:0] bnd_wlin;
	logic [12:0] bnd_rlin;
	desc_t       desc_m;
	logic        upd;
	logic [31:0] lo_x;
	logic [31:0] hi_x;
	logic [31:0] idx_x;
	logic        out_free;
	logic        fire;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign id_ok        = {5'd0, item.array_id} < ID_LIM;
	assign slot_ok      = {1'b0, item.dim_slot} < DIMS_LIM;
	assign pos_ok       = {1'b0, pos_q} < DIMS_LIM;
	assign bnd_wlin     = 13'(item.array_id) * 13'(MAX_DIMS) + 13'(item.dim_slot);
	assign bnd_rlin     = 13'(item.array_id) * 13'(MAX_DIMS) + 13'(pos_q);

	assign desc_we      = accept && (item.mode == MODE_DEFINE) && id_ok;
	assign desc_waddr   = id_ok ? AW'(item.array_id) : '0;
	assign desc_wdata   = '{base: item.base_addr, esize: item.elem_bytes,
		dims: item.dim_count};
	assign desc_re      = accept && (item.mode == MODE_INDEX);
	assign desc_raddr   = id_ok ? AW'(item.array_id) : '0;

	assign bnd_we       = accept && (item.mode == MODE_BOUND) && id_ok && slot_ok;
	assign bnd_waddr    = (id_ok && slot_ok) ? BW'(bnd_wlin) : '0;
	assign bnd_wdata    = '{lower: item.lower_bound, upper: item.upper_bound};
	assign bnd_re       = desc_re;
	assign bnd_raddr    = (id_ok && pos_ok) ? BW'(bnd_rlin) : '0;

	assign desc_m       = id_ok_s1 ? desc_rdata : '0;
	assign upd          = (pos_q < desc_m.dims) && pos_ok;
	assign lo_x         = {{16{bnd_rdata.lower[15]}}, bnd_rdata.lower};
	assign hi_x         = {{16{bnd_rdata.upper[15]}}, bnd_rdata.upper};
	assign idx_x        = {{16{idx_s1[15]}}, idx_s1};
	assign out_free     = !result_valid_q || !result_stall;
	assign fire         = (state_q == ST_SCALE) && out_free;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			offset_q       <= '0;
			pos_q          <= '0;
			result_valid_q <= 1'b0;
			last_s1        <= 1'b0;
			id_ok_s1       <= 1'b0;
			idx_s1         <= '0;
			extent_s2      <= '0;
			diff_s2        <= '0;
			base_s2        <= '0;
			esize_s2       <= '0;
			err_s2         <= 1'b0;
			result_q       <= '0;
		end else begin
			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (item.mode == MODE_INDEX)) begin
						last_s1  <= item.last_index;
						id_ok_s1 <= id_ok;
						idx_s1   <= item.index_value;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					extent_s2 <= upd ? (hi_x - lo_x + 32'd1) : 32'd1;
					diff_s2   <= upd ? (idx_x - lo_x) : 32'd0;
					base_s2   <= desc_m.base;
					esize_s2  <= desc_m.esize;
					err_s2    <= ({1'b0, pos_q} + 5'd1) != {1'b0, desc_m.dims};
					state_q   <= ST_MAC;
				end
				ST_MAC: begin
					offset_q <= 32'(offset_q * extent_s2) + diff_s2;
					if (last_s1) begin
						pos_q   <= '0;
						state_q <= ST_SCALE;
					end else begin
						if (pos_q != 4'hF) begin
							pos_q <= pos_q + 4'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCALE: begin
					if (out_free) begin
						result_q.phys_addr   <= base_s2 + 32'(offset_q * {16'd0, esize_s2});
						result_q.count_error <= err_s2;
						offset_q             <= '0;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/multidim_array_address_map.sv =====
// Top level of the row-major array address generator.
// Define requests (mode 0) store an array descriptor and bound requests (mode 1) store
// one dimension's bounds. Index requests (mode 2) arrive first dimension first and fold
// offset = offset * extent + (index - lower) into a running offset; a non-final index
// holds off further requests through its read and multiply-add steps, and the index
// marked last then adds a scale step and presents base + offset * elem_bytes (modulo
// 2^32) with a flag for a wrong index count. Each index runs through the registered read
// of the descriptor and bound memories, then the shared multiply-add on the running offset.
// The result sits in an output register, so new requests are taken while it waits; only
// a further final index holds in its scale step until the previous result is taken.
module multidim_array_address_map import mam_pkg::*; #(
	parameter int MAX_ARRAYS = 16,
	parameter int MAX_DIMS   = 10
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int BND_DEPTH = MAX_ARRAYS * MAX_DIMS;
	localparam int AW = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
	localparam int BW = (BND_DEPTH > 1) ? $clog2(BND_DEPTH) : 1;

	logic          desc_we;
	logic [AW-1:0] desc_waddr;
	desc_t         desc_wdata;
	logic          desc_re;
	logic [AW-1:0] desc_raddr;
	desc_t         desc_rdata;
	logic          bnd_we;
	logic [BW-1:0] bnd_waddr;
	bound_t        bnd_wdata;
	logic          bnd_re;
	logic [BW-1:0] bnd_raddr;
	bound_t        bnd_rdata;

	mam_ram #(
		.WIDTH ($bits(desc_t)),
		.DEPTH (MAX_ARRAYS),
		.AW    (AW)
	) u_desc_ram (
		.clk   (clk),
		.we    (desc_we),
		.waddr (desc_waddr),
		.wdata (desc_wdata),
		.re    (desc_re),
		.raddr (desc_raddr),
		.rdata (desc_rdata)
	);

	mam_ram #(
		.WIDTH ($bits(bound_t)),
		.DEPTH (BND_DEPTH),
		.AW    (BW)
	) u_bnd_ram (
		.clk   (clk),
		.we    (bnd_we),
		.waddr (bnd_waddr),
		.wdata (bnd_wdata),
		.re    (bnd_re),
		.raddr (bnd_raddr),
		.rdata (bnd_rdata)
	);

	mam_seq #(
		.MAX_ARRAYS (MAX_ARRAYS),
		.MAX_DIMS   (MAX_DIMS),
		.AW         (AW),
		.BW         (BW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.desc_we      (desc_we),
		.desc_waddr   (desc_waddr),
		.desc_wdata   (desc_wdata),
		.desc_re      (desc_re),
		.desc_raddr   (desc_raddr),
		.desc_rdata   (desc_rdata),
		.bnd_we       (bnd_we),
		.bnd_waddr    (bnd_waddr),
		.bnd_wdata    (bnd_wdata),
		.bnd_re       (bnd_re),
		.bnd_raddr    (bnd_raddr),
		.bnd_rdata    (bnd_rdata)
	);

endmodule
